// File: src/sle_pkg.sv
// ----------------------------------------------------------------------------
// sle_pkg - shared types and constants for the sorted list engine
// Command and status codes, field widths and the per-cycle cell control word.
// ----------------------------------------------------------------------------
package sle_pkg;

  localparam int DEPTH_DEF = 64;

  localparam int CMD_W    = 2;
  localparam int VAL_W    = 32;
  localparam int STATUS_W = 2;
  localparam int FIELD_W  = 7;   // width of the position and count result fields

  localparam int IN_DATA_W  = 40;  // command + value, padded to whole bytes
  localparam int OUT_DATA_W = 16;  // status + position + count

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_SEARCH = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOTFOUND = 2'd2
  } status_t;

  // control word broadcast down the row of cells
  typedef struct packed {
    logic cmp;   // capture compare flags against the key
    logic ins;   // shift up and write the key
    logic del;   // shift down over the removed entry
    cmd_t cmd;   // selects which boundary mark a cell reports
  } sle_ctl_t;

endpackage

// File: src/sle_cell.sv
// ----------------------------------------------------------------------------
// sle_cell - one slot of the sorted list
// Holds one entry, compares it with the broadcast key and moves data to or
// from its neighbors on insert and delete.
// ----------------------------------------------------------------------------
module sle_cell
  import sle_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  parameter int IDX   = 0
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  sle_ctl_t                       ctl,
  input  logic signed [VAL_W-1:0]        key,
  input  logic [$clog2(DEPTH+1)-1:0]     count,
  input  logic signed [VAL_W-1:0]        prev_val,
  input  logic                           prev_gtx,
  input  logic                           prev_eq,
  input  logic signed [VAL_W-1:0]        next_val,
  input  logic                           next_eq,
  output logic signed [VAL_W-1:0]        val,
  output logic                           gtx,
  output logic                           eq,
  output logic                           mark
);

  localparam int CW = $clog2(DEPTH+1);

  logic signed [VAL_W-1:0] val_r, val_nxt;
  logic                    gt_r, gt_nxt;
  logic                    eq_r, eq_nxt;
  logic                    occupied;
  logic                    append_slot;
  logic                    last_eq;

  assign occupied    = count > CW'(IDX);
  assign append_slot = count == CW'(IDX);

  // append slot counts as "greater" so an insert with no greater entry lands there
  assign gtx     = gt_r | append_slot;
  assign eq      = eq_r;
  assign val     = val_r;
  assign last_eq = eq_r & ~next_eq;

  always_comb begin
    case (ctl.cmd)
      CMD_INSERT: mark = gtx & ~prev_gtx;
      CMD_DELETE: mark = last_eq;
      CMD_SEARCH: mark = eq_r & ~prev_eq;
      default:    mark = 1'b0;
    endcase
  end

  always_comb begin
    gt_nxt  = gt_r;
    eq_nxt  = eq_r;
    val_nxt = val_r;
    if (ctl.cmp) begin
      gt_nxt = occupied & (val_r > key);
      eq_nxt = occupied & (val_r == key);
    end
    if (ctl.ins && gtx) begin
      val_nxt = prev_gtx ? prev_val : key;
    end
    if (ctl.del && (gt_r || last_eq)) begin
      val_nxt = next_val;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    if (!rst_n) begin
      gt_r <= 1'b0;
      eq_r <= 1'b0;
    end else begin
      gt_r <= gt_nxt;
      eq_r <= eq_nxt;
    end
  end

endmodule

// File: src/sle_pos_enc.sv
// ----------------------------------------------------------------------------
// sle_pos_enc - boundary position encoder
// Turns the one-hot boundary marks of the cell row into a binary index.
// ----------------------------------------------------------------------------
module sle_pos_enc
  import sle_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic [DEPTH-1:0]             marks,
  output logic [$clog2(DEPTH)-1:0]     idx,
  output logic                         any
);

  localparam int IW = $clog2(DEPTH);

  always_comb begin
    idx = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (marks[i]) begin
        idx = idx | IW'(i);
      end
    end
  end

  assign any = |marks;

endmodule

// File: src/sorted_list_engine.sv
// ----------------------------------------------------------------------------
// sorted_list_engine - ascending list of signed values with insert/delete/search
// Sequence: accept, compare, update; the next request is accepted only after
//   the update, which registers the result once the result register has room;
//   the row of cells compares all entries in the compare state and shifts them in the update state.
// Reset: rst_n synchronous active low empties the list (count to zero);
//   entry contents are left as they are and never read until written.
// ----------------------------------------------------------------------------
module sorted_list_engine
  import sle_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // request channel
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_DATA_W-1:0]   in_tdata,   // [1:0] command, [33:2] value, rest zero
  // result channel
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_DATA_W-1:0]  out_tdata   // [1:0] status, [8:2] position, [15:9] count
);

  localparam int CW  = $clog2(DEPTH+1);
  localparam int IW  = $clog2(DEPTH);
  localparam int PWX = (IW > FIELD_W) ? IW : FIELD_W;
  localparam int CWX = (CW > FIELD_W) ? CW : FIELD_W;

  // one-hot sequencer: wait for a request, compare, update and post the result
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CMP  = 3'b010,
    S_UPD  = 3'b100
  } state_t;

  state_t                  state_r, state_nxt;
  cmd_t                    cmd_r, cmd_nxt;
  logic signed [VAL_W-1:0] key_r, key_nxt;
  logic [CW-1:0]           count_r, count_nxt;

  logic                    out_valid_r, out_valid_nxt;
  status_t                 out_status_r, out_status_nxt;
  logic [FIELD_W-1:0]      out_pos_r, out_pos_nxt;
  logic [FIELD_W-1:0]      out_count_r, out_count_nxt;

  logic                    upd_go;
  logic                    full;
  logic                    found;
  sle_ctl_t                ctl;

  logic signed [VAL_W-1:0] cell_val  [DEPTH];
  logic [DEPTH-1:0]        cell_gtx;
  logic [DEPTH-1:0]        cell_eq;
  logic [DEPTH-1:0]        cell_mark;

  logic [IW-1:0]           enc_idx;
  logic                    enc_any;
  logic [PWX-1:0]          pos_ext;
  logic [CWX-1:0]          count_ext;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_count_r, out_pos_r, out_status_r};

  assign full   = (count_r == CW'(DEPTH));
  assign found  = |cell_eq;
  // update only once the result register has room, so nothing is dropped
  assign upd_go = (state_r == S_UPD) && (!out_valid_r || out_tready);

  // broadcast control word for the cell row
  always_comb begin
    ctl.cmp = (state_r == S_CMP);
    ctl.ins = upd_go && (cmd_r == CMD_INSERT) && !full;
    ctl.del = upd_go && (cmd_r == CMD_DELETE) && found;
    ctl.cmd = cmd_r;
  end

  // the row of cells; besides the broadcast control word, key and fill count, each talks only to its neighbors
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [VAL_W-1:0] p_val, n_val;
    logic                    p_gtx, p_eq, n_eq;

    if (i == 0) begin : g_head
      assign p_val = key_r;
      assign p_gtx = 1'b0;
      assign p_eq  = 1'b0;
    end else begin : g_mid_p
      assign p_val = cell_val[i-1];
      assign p_gtx = cell_gtx[i-1];
      assign p_eq  = cell_eq[i-1];
    end

    if (i == DEPTH-1) begin : g_tail
      assign n_val = cell_val[i];
      assign n_eq  = 1'b0;
    end else begin : g_mid_n
      assign n_val = cell_val[i+1];
      assign n_eq  = cell_eq[i+1];
    end

    sle_cell #(
      .DEPTH (DEPTH),
      .IDX   (i)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .key      (key_r),
      .count    (count_r),
      .prev_val (p_val),
      .prev_gtx (p_gtx),
      .prev_eq  (p_eq),
      .next_val (n_val),
      .next_eq  (n_eq),
      .val      (cell_val[i]),
      .gtx      (cell_gtx[i]),
      .eq       (cell_eq[i]),
      .mark     (cell_mark[i])
    );
  end

  sle_pos_enc #(
    .DEPTH (DEPTH)
  ) u_pos_enc (
    .marks (cell_mark),
    .idx   (enc_idx),
    .any   (enc_any)
  );

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    key_nxt        = key_r;
    count_nxt      = count_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_pos_nxt    = out_pos_r;
    out_count_nxt  = out_count_r;
    pos_ext        = PWX'(enc_idx);
    count_ext      = '0;

    // drop the result once taken
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt   = cmd_t'(in_tdata[CMD_W-1:0]);
          key_nxt   = in_tdata[CMD_W +: VAL_W];
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        state_nxt = S_UPD;
      end
      S_UPD: begin
        if (upd_go) begin
          out_status_nxt = ST_OK;
          out_pos_nxt    = '0;
          case (cmd_r)
            CMD_INSERT: begin
              if (full) begin
                out_status_nxt = ST_FULL;
              end else begin
                out_pos_nxt = pos_ext[FIELD_W-1:0];
                count_nxt   = count_r + CW'(1);
              end
            end
            CMD_DELETE: begin
              if (!found) begin
                out_status_nxt = ST_NOTFOUND;
              end else begin
                out_pos_nxt = pos_ext[FIELD_W-1:0];
                count_nxt   = count_r - CW'(1);
              end
            end
            CMD_SEARCH: begin
              if (!found) begin
                out_status_nxt = ST_NOTFOUND;
              end else begin
                out_pos_nxt = pos_ext[FIELD_W-1:0];
              end
            end
            default: begin
              out_status_nxt = ST_OK;
            end
          endcase
          count_ext     = CWX'(count_nxt);
          out_count_nxt = count_ext[FIELD_W-1:0];
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    key_r        <= key_nxt;
    out_status_r <= out_status_nxt;
    out_pos_r    <= out_pos_nxt;
    out_count_r  <= out_count_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // ------------------------------------------------------------------------
  // assertions
  // ------------------------------------------------------------------------
  a_count_range : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("fill count beyond depth");

  a_single_mark : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPD) |-> $onehot0(cell_mark))
    else $error("more than one boundary cell marked");

  a_ins_mark : assert property (@(posedge clk) disable iff (!rst_n)
    ctl.ins |-> enc_any)
    else $error("insert without an insertion point");

  a_ins_count : assert property (@(posedge clk) disable iff (!rst_n)
    ctl.ins |=> count_r == $past(count_r) + CW'(1))
    else $error("insert did not grow the list");

  a_search_stable : assert property (@(posedge clk) disable iff (!rst_n)
    (upd_go && (cmd_r == CMD_SEARCH || cmd_r == CMD_NOP)) |=> $stable(count_r))
    else $error("search changed the fill count");

endmodule

// File: test/sorted_list_engine_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_list_engine_tb - self-checking bench for the sorted list engine
// Drives insert, delete, search and unused-code requests into the block and
// keeps a behavioral copy of the ascending list. Each returned status,
// position and count is checked in order against that copy. The run covers
// empty and full lists, duplicates and value extremes, then random traffic
// under three idling mixes and one long result-side hold.
// ----------------------------------------------------------------------------
module sorted_list_engine_tb
  import sle_pkg::*;
();

  localparam int DEPTH = DEPTH_DEF;
  localparam int CLK_HALF_NS = 6;
  localparam int RESET_CYCLES = 5;
  localparam int DRAIN_CYCLES = 10;
  localparam int HOLD_CYCLES = 400;          // long result-side stall
  localparam int RUN_LIMIT_NS = 3_600_000;
  localparam int PRINT_CAP = 100;

  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

  typedef struct {
    status_t            status;
    logic [FIELD_W-1:0] position;
    logic [FIELD_W-1:0] count;
  } list_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  // behavioral copy of the list
  logic signed [VAL_W-1:0] list_vals [DEPTH];
  int                      list_fill = 0;

  list_result_t pending_results[$];
  int           mismatch_count = 0;

  // idling mix, in percent of cycles
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // long hold requested by a test, counted down in the receiver process
  int hold_cycles_req = 0;
  int hold_req_tag = 0;
  int hold_tag_seen = 0;
  int hold_left = 0;

  sorted_list_engine #(.DEPTH(DEPTH)) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #(CLK_HALF_NS) clk = ~clk;

  // Apply one command to the list copy and return the result it yields.
  function automatic list_result_t list_apply(input cmd_t cmd,
                                              input logic signed [VAL_W-1:0] value);
    list_result_t res;
    int           pos;
    bit           hit;
    res.status = ST_OK;
    res.position = '0;
    pos = 0;
    hit = 1'b0;
    case (cmd)
      CMD_INSERT: begin
        if (list_fill >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          // land before the first strictly greater entry, else append
          pos = list_fill;
          for (int i = 0; i < list_fill; i++) begin
            if (list_vals[i] > value) begin
              pos = i;
              break;
            end
          end
          for (int i = list_fill; i > pos; i--) list_vals[i] = list_vals[i-1];
          list_vals[pos] = value;
          list_fill++;
          res.position = pos[FIELD_W-1:0];
        end
      end
      CMD_DELETE: begin
        // remove the last occurrence
        for (int i = 0; i < list_fill; i++) begin
          if (list_vals[i] == value) begin
            pos = i;
            hit = 1'b1;
          end
        end
        if (!hit) begin
          res.status = ST_NOTFOUND;
        end else begin
          for (int i = pos; i + 1 < list_fill; i++) list_vals[i] = list_vals[i+1];
          list_fill--;
          res.position = pos[FIELD_W-1:0];
        end
      end
      CMD_SEARCH: begin
        // report the first occurrence
        for (int i = 0; i < list_fill; i++) begin
          if (list_vals[i] == value) begin
            pos = i;
            hit = 1'b1;
            break;
          end
        end
        if (hit) res.position = pos[FIELD_W-1:0];
        else res.status = ST_NOTFOUND;
      end
      default: ;  // unused code: nothing changes
    endcase
    res.count = list_fill[FIELD_W-1:0];
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatch_count < PRINT_CAP)
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  // Offer one request, wait for its handshake, then record what it should return.
  task automatic send_request(input cmd_t cmd, input logic signed [VAL_W-1:0] value);
    logic [IN_DATA_W-1:0] word;
    int                   gap;
    word = '0;
    word[CMD_W-1:0] = cmd;
    word[CMD_W +: VAL_W] = value;
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      gap = $urandom_range(1, 4);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= word;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_results.push_back(list_apply(cmd, value));
  endtask

  // Mostly wide noise, plus values already held, small clustered values and extremes.
  function automatic logic signed [VAL_W-1:0] pick_value();
    int sel;
    sel = $urandom_range(9);
    if (sel <= 3) return $urandom;
    if (sel <= 5) return $urandom_range(8) - 4;
    if (sel == 6) begin
      case ($urandom_range(3))
        0: return VAL_MIN;
        1: return VAL_MAX;
        2: return 0;
        default: return -1;
      endcase
    end
    if (list_fill > 0) return list_vals[$urandom_range(list_fill - 1)];
    return $urandom;
  endfunction

  // Swing the fill level between empty and full so both ends get visited.
  task automatic run_random(input int n_items);
    bit grow;
    int r;
    grow = 1'b1;
    for (int k = 0; k < n_items; k++) begin
      if (list_fill >= DEPTH) grow = 1'b0;
      if (list_fill == 0) grow = 1'b1;
      r = $urandom_range(99);
      if (r < 5) send_request(CMD_NOP, $urandom);
      else if (r < 20) send_request(CMD_SEARCH, pick_value());
      else if (r < (grow ? 72 : 40)) send_request(CMD_INSERT, pick_value());
      else send_request(CMD_DELETE, pick_value());
    end
  endtask

  task automatic test_directed();
    // empty list: nothing to find or remove
    send_request(CMD_SEARCH, 0);
    send_request(CMD_DELETE, 0);
    send_request(CMD_NOP, -1);
    // ordering, extremes and duplicates
    send_request(CMD_INSERT, 0);
    send_request(CMD_INSERT, VAL_MAX);
    send_request(CMD_INSERT, VAL_MIN);
    send_request(CMD_INSERT, 0);
    send_request(CMD_INSERT, -1);
    send_request(CMD_INSERT, 0);
    send_request(CMD_INSERT, 32'sh5555_5555);
    send_request(CMD_INSERT, 32'shAAAA_AAAA);
    // first match on search, last match on delete
    send_request(CMD_SEARCH, 0);
    send_request(CMD_DELETE, 0);
    send_request(CMD_SEARCH, VAL_MAX);
    send_request(CMD_SEARCH, VAL_MIN);
    send_request(CMD_SEARCH, 5);
    send_request(CMD_DELETE, 7);
    send_request(CMD_NOP, VAL_MAX);
    send_request(CMD_DELETE, VAL_MAX);
    send_request(CMD_DELETE, VAL_MIN);
    send_request(CMD_DELETE, -1);
  endtask

  task automatic test_full_list();
    while (list_fill < DEPTH) send_request(CMD_INSERT, pick_value());
    // refused inserts leave the list alone
    send_request(CMD_INSERT, VAL_MIN);
    send_request(CMD_INSERT, VAL_MAX);
    send_request(CMD_INSERT, $urandom);
    send_request(CMD_SEARCH, list_vals[DEPTH-1]);
    send_request(CMD_NOP, 0);
    send_request(CMD_DELETE, list_vals[0]);
    send_request(CMD_INSERT, VAL_MAX);
    // drain in random order
    while (list_fill > 0) send_request(CMD_DELETE, list_vals[$urandom_range(list_fill - 1)]);
    send_request(CMD_DELETE, VAL_MIN);
  endtask

  task automatic test_backpressure();
    // hold the result side long enough for the block to stall its input
    hold_cycles_req = HOLD_CYCLES;
    hold_req_tag++;
    run_random(40);
  endtask

  // Result side: random stalls, or a held-off stretch when a test asks for one.
  always @(posedge clk) begin
    if (hold_req_tag != hold_tag_seen) begin
      hold_tag_seen = hold_req_tag;
      hold_left = hold_cycles_req;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Compare each returned result with the oldest outstanding expectation.
  always @(posedge clk) begin : check_results
    list_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", out_tdata, 0);
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[STATUS_W-1:0] != want.status)
          report_mismatch("status", out_tdata[STATUS_W-1:0], want.status);
        if (out_tdata[STATUS_W +: FIELD_W] != want.position)
          report_mismatch("position", out_tdata[STATUS_W +: FIELD_W], want.position);
        if (out_tdata[STATUS_W + FIELD_W +: FIELD_W] != want.count)
          report_mismatch("count", out_tdata[STATUS_W + FIELD_W +: FIELD_W], want.count);
      end
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // sender idles lightly, receiver heavily
    send_idle_pct = 25;
    recv_idle_pct = 58;
    test_directed();
    test_full_list();
    run_random(600);

    // swap the idling sides
    send_idle_pct = 58;
    recv_idle_pct = 25;
    run_random(600);

    // no idling at all, plus one long hold on the result side
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_backpressure();
    run_random(600);

    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("sorted_list_engine_tb OK");
    end else begin
      $display("sorted_list_engine_tb NOT OK");
    end
    $finish;
  end

  // Stop a hung run.
  initial begin
    #(RUN_LIMIT_NS);
    $display("sorted_list_engine_tb NOT OK");
    $finish;
  end

endmodule
